[rtl/rgmc_pkg.sv]
// Shared types and codes for the relay guard with minimum cycle times.
package rgmc_pkg;

    // Input commands
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_REQUEST = 2'd1;
    localparam logic [1:0] CMD_FORCE   = 2'd2;
    localparam logic [1:0] CMD_SAMPLE  = 2'd3;

    // Reject reasons
    localparam logic [2:0] RSN_NONE     = 3'd0;
    localparam logic [2:0] RSN_FAILSAFE = 3'd1;
    localparam logic [2:0] RSN_COOLDOWN = 3'd2;
    localparam logic [2:0] RSN_CEILING  = 3'd3;
    localparam logic [2:0] RSN_STALE    = 3'd4;

    // Heater trip codes
    localparam logic [1:0] TRIP_NONE     = 2'd0;
    localparam logic [1:0] TRIP_MAX_ON   = 2'd1;
    localparam logic [1:0] TRIP_OVERTEMP = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_MIN_ON    = 3'd0;
    localparam logic [2:0] REG_MIN_OFF   = 3'd1;
    localparam logic [2:0] REG_MAX_ON    = 3'd2;
    localparam logic [2:0] REG_COOLDOWN  = 3'd3;
    localparam logic [2:0] REG_CEILING   = 3'd4;
    localparam logic [2:0] REG_STALE     = 3'd5;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;

    // Reset values of the configuration registers
    localparam logic [31:0]        RST_MAX_ON   = 32'd600000;
    localparam logic [31:0]        RST_COOLDOWN = 32'd300000;
    localparam logic signed [14:0] RST_CEILING  = 15'sd3500;
    localparam logic [31:0]        RST_STALE    = 32'd30000;

    typedef struct packed {
        logic [63:0]        min_on;
        logic [63:0]        min_off;
        logic [31:0]        max_on;
        logic [31:0]        cooldown;
        logic signed [14:0] ceiling;
        logic [31:0]        stale;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         command;
        logic [1:0]         channel;
        logic               want_on;
        logic               failsafe_active;
        logic               temp_valid;
        logic signed [14:0] temperature;
    } t_item;

    typedef struct packed {
        logic [3:0] relay_on;
        logic       accepted;
        logic [2:0] reject_reason;
        logic [1:0] heater_trip;
        logic       relays_changed;
    } t_result;

endpackage

[rtl/rgmc_cfg.sv]
// Configuration register file of the relay guard.
module rgmc_cfg
    import rgmc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Write the addressed register; ignore indexes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_on   <= '0;
            r_cfg.min_off  <= '0;
            r_cfg.max_on   <= RST_MAX_ON;
            r_cfg.cooldown <= RST_COOLDOWN;
            r_cfg.ceiling  <= RST_CEILING;
            r_cfg.stale    <= RST_STALE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MIN_ON:   r_cfg.min_on   <= i_cfg_data;
                REG_MIN_OFF:  r_cfg.min_off  <= i_cfg_data;
                REG_MAX_ON:   r_cfg.max_on   <= i_cfg_data[31:0];
                REG_COOLDOWN: r_cfg.cooldown <= i_cfg_data[31:0];
                REG_CEILING:  r_cfg.ceiling  <= $signed(i_cfg_data[14:0]);
                REG_STALE:    r_cfg.stale    <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/rgmc_core.sv]
// Relay state, timing records and the single-pass update for one item.
module rgmc_core
    import rgmc_pkg::*;
#(
    parameter int CHANNELS       = 4,
    parameter int HEATER_CHANNEL = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_go,
    input  t_item   i_item,
    output t_result o_res
);

    localparam bit HEATER_EN = (HEATER_CHANNEL < CHANNELS);
    localparam int HIDX      = HEATER_EN ? HEATER_CHANNEL : 0;
    localparam int PADW      = (CHANNELS < 4) ? 4 : CHANNELS;

    logic [31:0]         r_time, n_time;
    logic [CHANNELS-1:0] r_req, n_req;
    logic [CHANNELS-1:0] r_act, n_act;
    logic [31:0]         r_last_on  [CHANNELS];
    logic [31:0]         n_last_on  [CHANNELS];
    logic [31:0]         r_last_off [CHANNELS];
    logic [31:0]         n_last_off [CHANNELS];
    logic [31:0]         r_cool, n_cool;
    logic signed [14:0]  r_temp, n_temp;
    logic                r_temp_valid, n_temp_valid;
    logic [31:0]         r_temp_time, n_temp_time;

    logic [31:0]         time_tick;
    logic                too_hot;
    logic                ch_present;
    logic                heater_on_req;
    logic [PADW-1:0]     act_pad;
    t_result             res;

    assign time_tick     = r_time + 32'd1;
    assign too_hot       = r_temp_valid && ($signed(r_temp) >= $signed(i_cfg.ceiling));
    assign ch_present    = int'(i_item.channel) < CHANNELS;
    assign heater_on_req = HEATER_EN && (int'(i_item.channel) == HEATER_CHANNEL)
                           && i_item.want_on;

    // Work out the next state and the result of the current item
    always_comb begin
        n_time       = r_time;
        n_req        = r_req;
        n_act        = r_act;
        n_last_on    = r_last_on;
        n_last_off   = r_last_off;
        n_cool       = r_cool;
        n_temp       = r_temp;
        n_temp_valid = r_temp_valid;
        n_temp_time  = r_temp_time;

        res.relay_on       = '0;
        res.accepted       = 1'b1;
        res.reject_reason  = RSN_NONE;
        res.heater_trip    = TRIP_NONE;
        res.relays_changed = 1'b0;

        case (i_item.command)
            CMD_TICK: begin
                n_time = time_tick;
                // Move each relay whose minimum dwell has passed
                for (int i = 0; i < CHANNELS; i++) begin
                    if (r_req[i] != r_act[i]) begin
                        if (r_req[i]) begin
                            if (32'(time_tick - r_last_off[i]) >=
                                {16'd0, i_cfg.min_off[16*(i%4) +: 16]}) begin
                                n_act[i]           = 1'b1;
                                n_last_on[i]       = time_tick;
                                res.relays_changed = 1'b1;
                            end
                        end else begin
                            if (32'(time_tick - r_last_on[i]) >=
                                {16'd0, i_cfg.min_on[16*(i%4) +: 16]}) begin
                                n_act[i]           = 1'b0;
                                n_last_off[i]      = time_tick;
                                res.relays_changed = 1'b1;
                            end
                        end
                    end
                end
                // Heater guard: max on time first, then over-temperature
                if (HEATER_EN && n_act[HIDX]) begin
                    if (32'(time_tick - n_last_on[HIDX]) >= i_cfg.max_on) begin
                        n_cool             = time_tick + i_cfg.cooldown;
                        n_req[HIDX]        = 1'b0;
                        n_act[HIDX]        = 1'b0;
                        n_last_off[HIDX]   = time_tick;
                        res.relays_changed = 1'b1;
                        res.heater_trip    = TRIP_MAX_ON;
                    end else if (too_hot) begin
                        n_req[HIDX]        = 1'b0;
                        n_act[HIDX]        = 1'b0;
                        n_last_off[HIDX]   = time_tick;
                        res.relays_changed = 1'b1;
                        res.heater_trip    = TRIP_OVERTEMP;
                    end
                end
            end
            CMD_REQUEST: begin
                if (!ch_present) begin
                    res.accepted = 1'b0;
                end else if (i_item.failsafe_active) begin
                    res.accepted      = 1'b0;
                    res.reject_reason = RSN_FAILSAFE;
                end else if (heater_on_req && (r_cool != 32'd0) && (r_time < r_cool)) begin
                    res.accepted      = 1'b0;
                    res.reject_reason = RSN_COOLDOWN;
                end else if (heater_on_req && too_hot) begin
                    res.accepted      = 1'b0;
                    res.reject_reason = RSN_CEILING;
                end else if (heater_on_req &&
                             (32'(r_time - r_temp_time) > i_cfg.stale)) begin
                    res.accepted      = 1'b0;
                    res.reject_reason = RSN_STALE;
                end else begin
                    for (int i = 0; i < CHANNELS; i++) begin
                        if (int'(i_item.channel) == i) begin
                            n_req[i] = i_item.want_on;
                        end
                    end
                end
            end
            CMD_FORCE: begin
                // Set requested and actual state at once
                for (int i = 0; i < CHANNELS; i++) begin
                    if (int'(i_item.channel) == i) begin
                        n_req[i] = i_item.want_on;
                        if (r_act[i] != i_item.want_on) begin
                            n_act[i]           = i_item.want_on;
                            res.relays_changed = 1'b1;
                            if (i_item.want_on) begin
                                n_last_on[i] = r_time;
                            end else begin
                                n_last_off[i] = r_time;
                            end
                        end
                    end
                end
            end
            default: begin
                // Temperature sample
                if (i_item.temp_valid) begin
                    n_temp       = i_item.temperature;
                    n_temp_valid = 1'b1;
                    n_temp_time  = r_time;
                end else begin
                    n_temp_valid = 1'b0;
                end
            end
        endcase

        act_pad      = PADW'(n_act);
        res.relay_on = act_pad[3:0];
    end

    // Commit state on each processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time       <= '0;
            r_req        <= '0;
            r_act        <= '0;
            r_cool       <= '0;
            r_temp       <= '0;
            r_temp_valid <= 1'b0;
            r_temp_time  <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_last_on[i]  <= '0;
                r_last_off[i] <= '0;
            end
        end else if (i_go) begin
            r_time       <= n_time;
            r_req        <= n_req;
            r_act        <= n_act;
            r_cool       <= n_cool;
            r_temp       <= n_temp;
            r_temp_valid <= n_temp_valid;
            r_temp_time  <= n_temp_time;
            r_last_on    <= n_last_on;
            r_last_off   <= n_last_off;
        end
    end

    assign o_res = res;

    // Time advances only on a processed tick
    a_time_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && i_item.command == CMD_TICK) |=> (r_time == $past(r_time) + 32'd1))
        else $error("time counter did not advance on tick");

    a_time_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_go && i_item.command == CMD_TICK) |=> $stable(r_time))
        else $error("time counter moved without a tick");

    // A max-on trip always arms a cooldown deadline
    a_cool_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && res.heater_trip == TRIP_MAX_ON) |=>
            (r_cool == $past(time_tick) + $past(i_cfg.cooldown)))
        else $error("cooldown deadline not set on max-on trip");

endmodule

[rtl/relay_guard_min_cycle_heater_safety.sv]
// Top level of the relay guard: input register, core update and result register.
//
// Supervises CHANNELS relays with minimum on/off dwell times and a heater guard
// (max on time with cooldown, temperature ceiling, stale-sample refusal). The
// block takes one item per clock cycle when not stalled and returns exactly one
// result per item. The item is held in the input register, then the whole update
// is a single combinational pass that writes the relay state and the result
// register together, so the result is valid after the input register and the
// result register. Throughput is one item per cycle while the result channel is
// not stalled; the input register and the result register part the two channels,
// so a stalled result holds one item while one more waits at input.
// Configuration writes take effect on the next cycle and belong in idle time.
module relay_guard_min_cycle_heater_safety
    import rgmc_pkg::*;
#(
    parameter int CHANNELS       = 4,
    parameter int HEATER_CHANNEL = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_command,
    input  logic [1:0]            i_channel,
    input  logic                  i_want_on,
    input  logic                  i_failsafe_active,
    input  logic                  i_temp_valid,
    input  logic signed [14:0]    i_temperature,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [3:0]            o_relay_on,
    output logic                  o_accepted,
    output logic [2:0]            o_reject_reason,
    output logic [1:0]            o_heater_trip,
    output logic                  o_relays_changed
);

    t_cfg    cfg;
    t_item   r_item;
    logic    r_in_valid;
    t_result core_res;
    t_result r_res;
    logic    r_out_valid;
    logic    advance;
    logic    in_xfer;

    // Process the held item when the result register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    rgmc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rgmc_core #(
        .CHANNELS       (CHANNELS),
        .HEATER_CHANNEL (HEATER_CHANNEL)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_go    (advance),
        .i_item  (r_item),
        .o_res   (core_res)
    );

    // Capture an input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item.command         <= i_command;
            r_item.channel         <= i_channel;
            r_item.want_on         <= i_want_on;
            r_item.failsafe_active <= i_failsafe_active;
            r_item.temp_valid      <= i_temp_valid;
            r_item.temperature     <= i_temperature;
        end
    end

    // Load the result register; drop valid once the result is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= core_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_relay_on       = r_res.relay_on;
    assign o_accepted       = r_res.accepted;
    assign o_reject_reason  = r_res.reject_reason;
    assign o_heater_trip    = r_res.heater_trip;
    assign o_relays_changed = r_res.relays_changed;

    // A reject reason always comes with a refused request
    a_reason_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_reject_reason != RSN_NONE) |-> !o_accepted)
        else $error("reject reason on an accepted item");

    // A heater trip always turns a relay off
    a_trip_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_heater_trip != TRIP_NONE) |-> (o_relays_changed && o_accepted))
        else $error("heater trip without a relay change");

    // A processed item always shows up as a valid result next cycle
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("processed item lost before the result register");

    // Input is stalled only while an item is held
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled with a free pipeline");

endmodule
